@@ hdl/ldba_pkg.sv @@
// Shared types and constants for the light depth-bin assignment block.
`timescale 1ns / 1ps

package ldba_pkg;

	localparam int NUM_BINS_DEF = 32;

	localparam int DEPTH_W  = 24;
	localparam int RADIUS_W = 23;
	localparam int SPAN_W   = 23;
	localparam int INDEX_W  = 16;
	localparam int SEL_W    = 5;
	localparam int BINO_W   = 5;
	localparam int ENTRY_W  = 2 * INDEX_W;

	localparam logic [SPAN_W-1:0]  BIN_DEPTH_RST = 23'd256;
	localparam logic [INDEX_W-1:0] EMPTY_LOW     = 16'hFFFF;
	localparam logic [INDEX_W-1:0] EMPTY_HIGH    = 16'h0000;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_DIV_NEAR,
		S_DIV_FAR,
		S_WALK_RD,
		S_WALK_WR,
		S_READ_RD,
		S_READ_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]                 operation;
		logic [INDEX_W-1:0]         light_index;
		logic signed [DEPTH_W-1:0]  center_depth;
		logic [RADIUS_W-1:0]        light_radius;
		logic [SEL_W-1:0]           bin_select;
	} in_item_t;

	typedef struct packed {
		logic [BINO_W-1:0]  first_bin;
		logic [BINO_W-1:0]  last_bin;
		logic [INDEX_W-1:0] bin_low_index;
		logic [INDEX_W-1:0] bin_high_index;
	} out_item_t;

endpackage

@@ hdl/ldba_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module ldba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/light_depth_bin_assign.sv @@
// Top level: depth-bin table with shared divider and bin walk sequencer.
`timescale 1ns / 1ps

// Channel   Dir  Handshake             Payload
// cfg       in   cfg_wr_en (no wait)   cfg_wr_data : bin depth, unsigned Q15.8
// in        in   in_valid / in_ready   in_data     : ldba_pkg::in_item_t
// out       out  out_valid / out_ready out_data    : ldba_pkg::out_item_t
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Insert: the shared restoring divider yields one quotient bit per
//   cycle, nearest then furthest depth; then each bin touched gets a
//   registered RAM read, then a write back.
// Clear: one bin written per cycle. Unused code: no bin touched.
// Read: one registered RAM read, or none for a select beyond the table.
// After reset a clearing pass over every bin runs before in_ready rises.
// The result sits in an output register; a stalled out channel holds the
//   sequencer in its final state until the pending transfer goes.

module light_depth_bin_assign #(
	parameter int NUM_BINS = ldba_pkg::NUM_BINS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [ldba_pkg::SPAN_W-1:0]   cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ldba_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ldba_pkg::out_item_t           out_data
);

	localparam int BIN_W = $clog2(NUM_BINS);
	localparam int CNT_W = $clog2(ldba_pkg::DEPTH_W);
	localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(ldba_pkg::DEPTH_W - 1);
	localparam logic [BIN_W-1:0] BIN_LAST  = BIN_W'(NUM_BINS - 1);
	localparam logic [ldba_pkg::DEPTH_W-1:0] QUO_LAST = ldba_pkg::DEPTH_W'(NUM_BINS - 1);

	ldba_pkg::state_t state_q, state_d;

	// configuration
	logic [ldba_pkg::SPAN_W-1:0]  bin_depth_q;

	// latched item
	ldba_pkg::op_t                op_q;
	logic [ldba_pkg::INDEX_W-1:0] idx_q;
	logic [ldba_pkg::SEL_W-1:0]   sel_q;
	logic [ldba_pkg::DEPTH_W-1:0] far_q;

	// shared divider
	logic [ldba_pkg::DEPTH_W-1:0] dvd_q;
	logic [ldba_pkg::SPAN_W-1:0]  rem_q;
	logic [ldba_pkg::DEPTH_W-1:0] quo_q;
	logic [CNT_W-1:0]             step_q;

	// bin range and walk / clear pointer
	logic [BIN_W-1:0]             first_q;
	logic [BIN_W-1:0]             last_q;
	logic [BIN_W-1:0]             ptr_q;

	ldba_pkg::out_item_t          res_q;
	ldba_pkg::out_item_t          out_data_q;
	logic                         out_valid_q;

	// combinational
	logic                         accept;
	logic                         out_free;
	logic                         sel_in_range;
	logic signed [ldba_pkg::DEPTH_W:0] near_s, far_s;
	logic [ldba_pkg::DEPTH_W-1:0] near_clamp, far_clamp;
	logic [ldba_pkg::SPAN_W-1:0]  divisor;
	logic [ldba_pkg::DEPTH_W-1:0] trial;
	logic                         ge;
	logic [ldba_pkg::SPAN_W-1:0]  rem_nx;
	logic [ldba_pkg::DEPTH_W-1:0] quo_nx;
	logic [BIN_W-1:0]             bin_sat;
	logic                         div_last;

	logic                         ram_we, ram_re;
	logic [BIN_W-1:0]             ram_waddr, ram_raddr;
	logic [ldba_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [ldba_pkg::INDEX_W-1:0] rd_low, rd_high, new_low, new_high;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// nearest and furthest depth, 25-bit signed, clamped at zero
	assign near_s = {in_data.center_depth[ldba_pkg::DEPTH_W-1], in_data.center_depth}
		- {2'b00, in_data.light_radius};
	assign far_s  = {in_data.center_depth[ldba_pkg::DEPTH_W-1], in_data.center_depth}
		+ {2'b00, in_data.light_radius};
	assign near_clamp = near_s[ldba_pkg::DEPTH_W] ? '0 : near_s[ldba_pkg::DEPTH_W-1:0];
	assign far_clamp  = far_s[ldba_pkg::DEPTH_W]  ? '0 : far_s[ldba_pkg::DEPTH_W-1:0];

	assign sel_in_range = 32'(sel_q) < NUM_BINS;

	// restoring divider step: one quotient bit per cycle, MSB first
	assign divisor  = (bin_depth_q == '0) ? ldba_pkg::SPAN_W'(1) : bin_depth_q;
	assign trial    = {rem_q, dvd_q[ldba_pkg::DEPTH_W-1]};
	assign ge       = trial >= {1'b0, divisor};
	assign rem_nx   = ge ? ldba_pkg::SPAN_W'(trial - {1'b0, divisor})
		: trial[ldba_pkg::SPAN_W-1:0];
	assign quo_nx   = {quo_q[ldba_pkg::DEPTH_W-2:0], ge};
	assign bin_sat  = (quo_nx > QUO_LAST) ? BIN_LAST : BIN_W'(quo_nx);
	assign div_last = step_q == STEP_LAST;

	// entry layout: low index in the upper half, high index in the lower half
	assign rd_low   = ram_rdata[ldba_pkg::ENTRY_W-1:ldba_pkg::INDEX_W];
	assign rd_high  = ram_rdata[ldba_pkg::INDEX_W-1:0];
	assign new_low  = (idx_q < rd_low)  ? idx_q : rd_low;
	assign new_high = (idx_q > rd_high) ? idx_q : rd_high;

	ldba_ram #(
		.WIDTH (ldba_pkg::ENTRY_W),
		.DEPTH (NUM_BINS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer: next state and RAM controls
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = {ldba_pkg::EMPTY_LOW, ldba_pkg::EMPTY_HIGH};
		ram_re    = 1'b0;
		ram_raddr = ptr_q;
		unique case (state_q)
			ldba_pkg::S_INIT: begin
				ram_we = 1'b1;
				if (ptr_q == BIN_LAST) begin
					state_d = ldba_pkg::S_IDLE;
				end
			end
			ldba_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (ldba_pkg::op_t'(in_data.operation))
						ldba_pkg::OP_CLEAR:  state_d = ldba_pkg::S_CLEAR;
						ldba_pkg::OP_INSERT: state_d = ldba_pkg::S_DIV_NEAR;
						ldba_pkg::OP_READ:   state_d = ldba_pkg::S_READ_RD;
						ldba_pkg::OP_NOP:    state_d = ldba_pkg::S_DONE;
						default:             state_d = ldba_pkg::S_DONE;
					endcase
				end
			end
			ldba_pkg::S_CLEAR: begin
				ram_we = 1'b1;
				if (ptr_q == BIN_LAST) begin
					state_d = ldba_pkg::S_DONE;
				end
			end
			ldba_pkg::S_DIV_NEAR: begin
				if (div_last) begin
					state_d = ldba_pkg::S_DIV_FAR;
				end
			end
			ldba_pkg::S_DIV_FAR: begin
				if (div_last) begin
					state_d = ldba_pkg::S_WALK_RD;
				end
			end
			ldba_pkg::S_WALK_RD: begin
				ram_re  = 1'b1;
				state_d = ldba_pkg::S_WALK_WR;
			end
			ldba_pkg::S_WALK_WR: begin
				ram_we    = 1'b1;
				ram_wdata = {new_low, new_high};
				state_d   = (ptr_q == last_q) ? ldba_pkg::S_DONE : ldba_pkg::S_WALK_RD;
			end
			ldba_pkg::S_READ_RD: begin
				// out-of-range select answers with an empty bin, preset on accept
				ram_re    = sel_in_range;
				ram_raddr = BIN_W'(sel_q);
				state_d   = sel_in_range ? ldba_pkg::S_READ_WR : ldba_pkg::S_DONE;
			end
			ldba_pkg::S_READ_WR: begin
				state_d = ldba_pkg::S_DONE;
			end
			ldba_pkg::S_DONE: begin
				if (out_free) begin
					state_d = ldba_pkg::S_IDLE;
				end
			end
			default: state_d = ldba_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ldba_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_depth_q <= ldba_pkg::BIN_DEPTH_RST;
			ptr_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				bin_depth_q <= cfg_wr_data;
			end
			if (accept) begin
				ptr_q  <= '0;
				step_q <= '0;
			end else if (state_q == ldba_pkg::S_INIT || state_q == ldba_pkg::S_CLEAR
					|| state_q == ldba_pkg::S_WALK_WR) begin
				ptr_q <= ptr_q + 1'b1;
			end else if (state_q == ldba_pkg::S_DIV_NEAR || state_q == ldba_pkg::S_DIV_FAR) begin
				step_q <= div_last ? '0 : step_q + 1'b1;
				if (state_q == ldba_pkg::S_DIV_FAR && div_last) begin
					ptr_q <= first_q;
				end
			end
			if (state_q == ldba_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and divider registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= ldba_pkg::op_t'(in_data.operation);
			idx_q <= in_data.light_index;
			sel_q <= in_data.bin_select;
			dvd_q <= near_clamp;
			far_q <= far_clamp;
			rem_q <= '0;
			quo_q <= '0;
			res_q <= '0;
			if (ldba_pkg::op_t'(in_data.operation) == ldba_pkg::OP_READ) begin
				res_q.bin_low_index <= ldba_pkg::EMPTY_LOW;
			end
		end else if (state_q == ldba_pkg::S_DIV_NEAR || state_q == ldba_pkg::S_DIV_FAR) begin
			if (div_last) begin
				// reload the divider for the furthest depth
				dvd_q <= far_q;
				rem_q <= '0;
				quo_q <= '0;
				if (state_q == ldba_pkg::S_DIV_NEAR) begin
					first_q <= bin_sat;
				end else begin
					last_q          <= bin_sat;
					res_q.first_bin <= ldba_pkg::BINO_W'(first_q);
					res_q.last_bin  <= ldba_pkg::BINO_W'(bin_sat);
				end
			end else begin
				dvd_q <= {dvd_q[ldba_pkg::DEPTH_W-2:0], 1'b0};
				rem_q <= rem_nx;
				quo_q <= quo_nx;
			end
		end else if (state_q == ldba_pkg::S_READ_WR && op_q == ldba_pkg::OP_READ) begin
			res_q.bin_low_index  <= rd_low;
			res_q.bin_high_index <= rd_high;
		end
		if (state_q == ldba_pkg::S_DONE && out_free) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
